@@ sv/abi_pkg.sv @@
// ----------------------------------------------------------------------------
// abi_pkg: shared types and constants of the breakpoint envelope
// Commands, status codes, register indexes and request/result payloads.
// ----------------------------------------------------------------------------
package abi_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned CfgIdxW       = 2;

  typedef enum logic [1:0] {
    CMD_QUERY = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DEL   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ADDED     = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_MODE = 2'd0,
    REG_HOLD      = 2'd1,
    REG_HELD_VAL  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        time_req;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } rsp_t;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

@@ sv/abi_div.sv @@
// ----------------------------------------------------------------------------
// abi_div: unsigned 64/32 restoring divider, one quotient bit per cycle
// Quotient is known to fit 32 bits; 64 iterations per division.
// ----------------------------------------------------------------------------
module abi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  abi_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);
  import abi_pkg::*;

  logic [63:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [63:0] quo_q, quo_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] shifted;

  // Load the operands on start, else shift in one dividend bit and try a subtract
  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[31:0], num_q[63]};
    if (req_i.start) begin
      num_d = req_i.dividend; den_d = req_i.divisor; rem_d = '0;
      quo_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[31:0];

  chk_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  chk_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
  chk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !done_d) else $error("divider done without work");

endmodule

@@ sv/abi_table.sv @@
// ----------------------------------------------------------------------------
// abi_table: breakpoint table memory with sequencer
// Times and values live in synchronous RAMs; search, shift and lookups
// run one entry per cycle, and the read data is registered.
// ----------------------------------------------------------------------------
module abi_table #(
  parameter int unsigned TableDepth = abi_pkg::TableDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  abi_pkg::req_t req_i,
  input  logic          step_mode_i,
  input  logic          hold_i,
  input  logic [31:0]   held_i,
  output logic          busy_o,
  output logic          valid_o,
  output abi_pkg::rsp_t rsp_o
);
  import abi_pkg::*;

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_SCAN  = 8'b00000010,
    S_SHUP  = 8'b00000100,
    S_SHDN  = 8'b00001000,
    S_RDK   = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_WAIT  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] tmem [TableDepth];
  logic [31:0] vmem [TableDepth];
  logic [31:0] t_rd, v_rd;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wt, wv;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;   // entry whose data arrives this cycle
  logic          rdv_q, rdv_d;   // read data valid
  req_t          req_q;
  logic [31:0]   pt_q, pt_d, pv_q, pv_d; // previous entry time/value
  logic          neg_q, neg_d;
  logic [31:0]   mag_q, mag_d, span_q, span_d;
  logic [31:0]   res_q, res_d;
  logic [2:0]    st_q, st_d;
  logic          done_q, done_d;
  div_req_t      dreq;
  logic          dv_done;
  logic [31:0]   quot;
  logic signed [32:0] dv;
  logic [31:0]   mag, dt, span;
  logic [63:0]   prod;

  // Memories: one write, one read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      tmem[waddr] <= wt;
      vmem[waddr] <= wv;
    end
    t_rd <= tmem[raddr];
    v_rd <= vmem[raddr];
  end

  assign dv   = {v_rd[31], v_rd} - {pv_q[31], pv_q};
  assign mag  = dv[32] ? 32'(-dv) : dv[31:0];
  assign dt   = req_q.time_req - pt_q;
  assign span = t_rd - pt_q;
  // Product from registered operands, formed in the cycle after the neighbor lookup
  assign prod = {32'd0, dt} * {32'd0, mag_q};

  // Sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; rdv_d = 1'b0;
    pt_d = pt_q; pv_d = pv_q; neg_d = neg_q; res_d = res_q; st_d = st_q;
    mag_d = mag_q; span_d = span_q;
    done_d = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wt = '0; wv = '0;
    dreq = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d = '0; st_d = ST_OK; idx_d = '0;
          raddr = '0; rdv_d = 1'b1;
          if (req_i.cmd == CMD_QUERY && (cnt_q == '0 || hold_i)) begin
            res_d = held_i; state_d = S_DONE;
          end else if (req_i.cmd == CMD_QUERY || req_i.cmd == CMD_ADD ||
                       req_i.cmd == CMD_DEL) begin
            if (cnt_q == '0) begin
              if (req_i.cmd == CMD_ADD) begin
                we = 1'b1; wt = req_i.time_req; wv = req_i.value;
                cnt_d = cnt_q + 1'b1; st_d = ST_ADDED;
              end else begin
                st_d = ST_NOT_FOUND;
              end
              state_d = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // Linear scan: t_rd/v_rd are entry idx_q
      S_SCAN: begin
        if (rdv_q) begin
          if (req_q.cmd == CMD_QUERY) begin
            if (t_rd > req_q.time_req) begin
              if (idx_q == '0) begin
                res_d = step_mode_i ? held_i : v_rd; state_d = S_DONE;
              end else if (step_mode_i) begin
                res_d = pv_q; state_d = S_DONE;
              end else begin
                // hold slope magnitude for the multiply and span for the divide
                neg_d = dv[32]; mag_d = mag; span_d = span;
                state_d = S_DIV;
              end
            end else if (idx_q + 1'b1 == cnt_q) begin
              res_d = v_rd; state_d = S_DONE;
            end
          end else if (req_q.cmd == CMD_ADD) begin
            if (t_rd == req_q.time_req) begin
              we = 1'b1; waddr = idx_q[AW-1:0]; wt = t_rd; wv = req_q.value;
              st_d = ST_REPLACED; state_d = S_DONE;
            end else if (t_rd > req_q.time_req) begin
              if (cnt_q == CW'(TableDepth)) begin
                st_d = ST_FULL; state_d = S_DONE;
              end else begin
                // insert here, carry old entry upward
                we = 1'b1; waddr = idx_q[AW-1:0];
                wt = req_q.time_req; wv = req_q.value;
                pt_d = t_rd; pv_d = v_rd; st_d = ST_ADDED;
                if (idx_q + 1'b1 == cnt_q) begin
                  state_d = S_RDK;
                end else begin
                  raddr = AW'(idx_q + 1'b1); rdv_d = 1'b1;
                  idx_d = idx_q + 1'b1; state_d = S_SHUP;
                end
              end
            end else if (idx_q + 1'b1 == cnt_q) begin
              if (cnt_q == CW'(TableDepth)) begin
                st_d = ST_FULL;
              end else begin
                we = 1'b1; waddr = AW'(cnt_q);
                wt = req_q.time_req; wv = req_q.value;
                cnt_d = cnt_q + 1'b1; st_d = ST_ADDED;
              end
              state_d = S_DONE;
            end
          end else begin
            if (t_rd == req_q.time_req) begin
              if (idx_q + 1'b1 == cnt_q) begin
                cnt_d = cnt_q - 1'b1; state_d = S_DONE;
              end else begin
                raddr = AW'(idx_q + 1'b1); rdv_d = 1'b1;
                idx_d = idx_q + 1'b1; state_d = S_SHDN;
              end
            end else if (t_rd > req_q.time_req || idx_q + 1'b1 == cnt_q) begin
              st_d = ST_NOT_FOUND; state_d = S_DONE;
            end
          end
          if (state_d == S_SCAN) begin
            pt_d = t_rd; pv_d = v_rd;
            raddr = AW'(idx_q + 1'b1); rdv_d = 1'b1; idx_d = idx_q + 1'b1;
          end
        end
      end
      // Shift up: write held entry into idx_q, hold the one read
      S_SHUP: begin
        if (rdv_q) begin
          we = 1'b1; waddr = idx_q[AW-1:0]; wt = pt_q; wv = pv_q;
          pt_d = t_rd; pv_d = v_rd;
          if (idx_q + 1'b1 == cnt_q) begin
            state_d = S_RDK;
          end else begin
            raddr = AW'(idx_q + 1'b1); rdv_d = 1'b1; idx_d = idx_q + 1'b1;
          end
        end
      end
      // Write the last carried entry at the old end
      S_RDK: begin
        we = 1'b1; waddr = AW'(cnt_q); wt = pt_q; wv = pv_q;
        cnt_d = cnt_q + 1'b1; state_d = S_DONE;
      end
      // Shift down: entry idx_q moves to idx_q-1
      S_SHDN: begin
        if (rdv_q) begin
          we = 1'b1; waddr = AW'(idx_q - 1'b1); wt = t_rd; wv = v_rd;
          if (idx_q + 1'b1 == cnt_q) begin
            cnt_d = cnt_q - 1'b1; state_d = S_DONE;
          end else begin
            raddr = AW'(idx_q + 1'b1); rdv_d = 1'b1; idx_d = idx_q + 1'b1;
          end
        end
      end
      // Launch the divide with the product of the registered operands
      S_DIV: begin
        dreq.start = 1'b1; dreq.dividend = prod; dreq.divisor = span_q;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (dv_done) begin
          res_d = neg_q ? pv_q - quot : pv_q + quot; state_d = S_DONE;
        end
      end
      S_DONE: begin
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  abi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (dv_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rdv_q <= 1'b0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rdv_q <= rdv_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) req_q <= req_i;
    idx_q <= idx_d; pt_q <= pt_d; pv_q <= pv_d; neg_q <= neg_d;
    mag_q <= mag_d; span_q <= span_d;
    res_q <= res_d; st_q <= st_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign valid_o = done_q;
  assign rsp_o.result_value = res_q;
  assign rsp_o.status = st_q;

  chk_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TableDepth)) else $error("point count overflow");
  chk_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result while busy");
  chk_we_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> {1'b0, waddr} <= cnt_q) else $error("write beyond table end");

endmodule

@@ sv/automation_breakpoint_interpolator_core.sv @@
// Held-value and empty-table answers skip the scan; other requests scan the
// table entry by entry, an insert or delete then shifts each moved entry,
// and a linear interpolation runs the 64-step divider. The busy output
// stays high while a request is in flight.
// Results appear for one cycle on valid_o; the receiver cannot stall.
// Reset empties the table and clears the configuration registers.
// ----------------------------------------------------------------------------
// automation_breakpoint_interpolator_core: breakpoint envelope top level
// Configuration registers and the table sequencer.
// ----------------------------------------------------------------------------
module automation_breakpoint_interpolator_core #(
  parameter int unsigned TableDepth = abi_pkg::TableDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  abi_pkg::req_t               req_i,
  output logic                        valid_o,
  output abi_pkg::rsp_t               rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [abi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i
);
  import abi_pkg::*;

  logic        step_q, hold_q;
  logic [31:0] held_q;

  // Register writes, held off while a request is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0; hold_q <= 1'b0; held_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        REG_STEP_MODE: step_q <= cfg_data_i[0];
        REG_HOLD:      hold_q <= cfg_data_i[0];
        REG_HELD_VAL:  held_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = !busy;

  abi_table #(.TableDepth(TableDepth)) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !busy),
    .req_i       (req_i),
    .step_mode_i (step_q),
    .hold_i      (hold_q),
    .held_i      (held_q),
    .busy_o      (busy),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the breakpoint envelope core
// Drives add, delete and query requests through the start/busy port, models
// the sorted breakpoint table and the interpolation, and compares each result.
// ----------------------------------------------------------------------------
module tb;
  import abi_pkg::*;

  localparam int unsigned Depth    = TableDepthDef;
  localparam int unsigned Watchdog = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  req_t       req_i = '0;
  logic       valid_o;
  rsp_t       rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  automation_breakpoint_interpolator_core u_top (
    .clk_i, .rst_ni, .start, .busy, .req_i, .valid_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Envelope model state
  logic [31:0]        bp_time [Depth];
  logic signed [31:0] bp_val  [Depth];
  int unsigned        bp_count;
  logic               mode_step, mode_hold;
  logic signed [31:0] hold_val;

  rsp_t        rsp_pending[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  logic        timed_out;

  function automatic int unsigned find_time(logic [31:0] t);
    for (int unsigned i = 0; i < bp_count; i++) if (bp_time[i] == t) return i;
    return bp_count;
  endfunction

  function automatic int unsigned first_later(logic [31:0] t);
    for (int unsigned i = 0; i < bp_count; i++) if (bp_time[i] > t) return i;
    return bp_count;
  endfunction

  function automatic logic signed [31:0] envelope_at(logic [31:0] t);
    int unsigned k;
    logic [31:0] dt, span, mag, q;
    logic signed [63:0] v1, v2, dv;
    logic [63:0] prod;
    if (bp_count == 0 || mode_hold) return hold_val;
    k = first_later(t);
    if (k >= bp_count) return bp_val[bp_count-1];
    if (mode_step) return (k == 0) ? hold_val : bp_val[k-1];
    if (k == 0) return bp_val[0];
    v1 = bp_val[k-1];
    v2 = bp_val[k];
    dt = t - bp_time[k-1];
    span = bp_time[k] - bp_time[k-1];
    dv = v2 - v1;
    mag = (dv < 0) ? 32'(-dv) : 32'(dv);
    prod = 64'(dt) * 64'(mag);
    q = 32'(prod / 64'(span));
    return (dv < 0) ? 32'(v1 - 64'(q)) : 32'(v1 + 64'(q));
  endfunction

  // Apply one request to the table model and return its result
  function automatic rsp_t envelope_step(req_t r);
    rsp_t o;
    int unsigned i, pos;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_QUERY: o.result_value = envelope_at(r.time_req);
      CMD_ADD: begin
        i = find_time(r.time_req);
        if (i < bp_count) begin
          bp_val[i] = r.value;
          o.status = ST_REPLACED;
        end else if (bp_count >= Depth) begin
          o.status = ST_FULL;
        end else begin
          pos = first_later(r.time_req);
          for (int unsigned j = bp_count; j > pos; j--) begin
            bp_time[j] = bp_time[j-1];
            bp_val[j]  = bp_val[j-1];
          end
          bp_time[pos] = r.time_req;
          bp_val[pos]  = r.value;
          bp_count++;
          o.status = ST_ADDED;
        end
      end
      CMD_DEL: begin
        i = find_time(r.time_req);
        if (i >= bp_count) begin
          o.status = ST_NOT_FOUND;
        end else begin
          for (int unsigned j = i; j + 1 < bp_count; j++) begin
            bp_time[j] = bp_time[j+1];
            bp_val[j]  = bp_val[j+1];
          end
          bp_count--;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Send one request, with a random idle gap before it; start stays high
  // after acceptance, which is harmless since busy is high the next cycle
  task automatic send_request(logic [1:0] cmd, logic [31:0] t, logic [31:0] v);
    req_t r;
    r.cmd = cmd;
    r.time_req = t;
    r.value = v;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    rsp_pending.push_back(envelope_step(r));
    @(negedge clk_i);
  endtask

  // Let the block drain, then wait out its worst latency
  task automatic drain();
    start <= 1'b0;
    while (rsp_pending.size() != 0) @(posedge clk_i);
    repeat (Depth + 80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_STEP_MODE: mode_step = data[0];
      REG_HOLD:      mode_hold = data[0];
      REG_HELD_VAL:  hold_val  = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(logic st, logic hd, logic [31:0] hv);
    write_reg(REG_STEP_MODE, {31'b0, st});
    write_reg(REG_HOLD, {31'b0, hd});
    write_reg(REG_HELD_VAL, hv);
    cfg_valid_i <= 1'b0;
  endtask

  // Times often close together at either end, so adds, deletes and queries collide often
  function automatic logic [31:0] pick_time();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return 32'hFFFF_FFFF - $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_request(CMD_QUERY, 32'd5, 32'd0);
    send_request(CMD_DEL, 32'd5, 32'd0);
    send_request(CMD_ADD, 32'd100, 32'h8000_0000);
    send_request(CMD_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 32'd0, 32'd7);
    send_request(CMD_QUERY, 32'd0, 32'd0);
    send_request(CMD_QUERY, 32'd99, 32'd0);
    send_request(CMD_QUERY, 32'h8000_0000, 32'd0);
    send_request(CMD_QUERY, 32'hFFFF_FFFE, 32'd0);
    send_request(CMD_QUERY, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_ADD, 32'd100, 32'd55);
    send_request(CMD_DEL, 32'd0, 32'd0);
    send_request(CMD_QUERY, 32'd50, 32'd0);
    send_request(CMD_DEL, 32'd1234, 32'd0);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    set_config(1'b1, 1'b0, 32'h8000_0000);
    send_request(CMD_QUERY, 32'd3, 32'd0);
    send_request(CMD_QUERY, 32'd200, 32'd0);
    drain();
    set_config(1'b0, 1'b1, 32'h7FFF_FFFF);
    send_request(CMD_QUERY, 32'd200, 32'd0);
    drain();
  endtask

  // Fill to the limit, then full-table add, replace, query and delete
  task automatic test_full_table();
    set_config(1'b0, 1'b0, 32'd0);
    for (int i = 0; i < 70; i++) send_request(CMD_ADD, $urandom, $urandom);
    send_request(CMD_ADD, bp_time[3], 32'hDEAD_BEEF);
    for (int i = 0; i < 10; i++) send_request(CMD_QUERY, $urandom, 32'd0);
    while (bp_count > 2) send_request(CMD_DEL, bp_time[$urandom_range(bp_count-1)], 32'd0);
    drain();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle_pct);
    logic [1:0] c;
    send_idle_pct = idle_pct;
    set_config(1'($urandom_range(1)), $urandom_range(3) == 0, $urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: c = CMD_QUERY;
        4, 5, 6: c = CMD_ADD;
        7, 8: c = CMD_DEL;
        default: c = ($urandom_range(4) == 0) ? 2'd3 : CMD_QUERY;
      endcase
      if (c == CMD_DEL && bp_count != 0 && $urandom_range(1))
        send_request(c, bp_time[$urandom_range(bp_count-1)], $urandom);
      else
        send_request(c, pick_time(), $urandom);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (rsp_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", rsp_o);
      end else begin
        automatic rsp_t exp_rsp = rsp_pending.pop_front();
        if (rsp_o.result_value !== exp_rsp.result_value || rsp_o.status !== exp_rsp.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: value exp %0d got %0d, status exp %0d got %0d",
                     exp_rsp.result_value, rsp_o.result_value,
                     exp_rsp.status, rsp_o.status);
        end
      end
    end
  end

  // Count cycles with no request, result or register write accepted
  always @(posedge clk_i) begin
    if (valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    bp_count = 0;
    mode_step = 1'b0;
    mode_hold = 1'b0;
    hold_val = '0;
    send_idle_pct = 0;
    fork
      begin
        repeat (5) @(posedge clk_i);
        @(negedge clk_i);
        rst_ni = 1'b1;
        test_directed();
        test_full_table();
        test_random(100, 0);
        test_random(100, 75);
        test_random(100, 31);
        test_random(90, 0);
      end
      begin
        wait (idle_cycles >= Watchdog);
        timed_out = 1'b1;
      end
    join_any
    if (timed_out || mismatches != 0 || rsp_pending.size() != 0) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end
endmodule
